// File: design/counting_sort_frame_unit_macros.svh
// Assertion macros shared by the counting sort frame unit.
`ifndef COUNTING_SORT_FRAME_UNIT_MACROS_SVH
`define COUNTING_SORT_FRAME_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/csf_pkg.sv
// Types and constants of the counting sort frame unit.
package csf_pkg;

  localparam int unsigned VAL_W = 7;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ACC,
    ST_SRD,
    ST_SGET,
    ST_SEMIT
  } csf_state_t;

endpackage

// File: design/csf_if.sv
// Request channel interfaces of the counting sort frame unit.
interface csf_in_if import csf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sample_value;
  logic             frame_end;

  modport source (output valid, output sample_value, output frame_end, input ready);
  modport sink (input valid, input sample_value, input frame_end, output ready);
endinterface

interface csf_out_if import csf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sorted_value;
  logic             run_end;

  modport source (output valid, output sorted_value, output run_end, input ready);
  modport sink (input valid, input sorted_value, input run_end, output ready);
endinterface

// File: design/counting_sort_frame_unit.sv
// Counting sort of one frame: histogram memory, accumulate, scan and emit.
// Each input request is a memory read, then the incremented count written back.
// A frame end starts a scan (read, then fetch, per bin) up to the highest filled bin, plus one
// result per cycle while the output register is free; each scanned bin is written to zero.
// After reset a clearing pass zeroes every histogram bin; no input request
// is accepted until it ends. Reset is synchronous and active low.
`include "counting_sort_frame_unit_macros.svh"

module counting_sort_frame_unit import csf_pkg::*; #(
  parameter int unsigned VALUE_BINS = 128,
  parameter int unsigned FRAME_LEN  = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  csf_in_if.sink   in_chan,
  csf_out_if.source out_chan
);

  localparam int unsigned BW = (VALUE_BINS > 1) ? $clog2(VALUE_BINS) : 1;
  localparam int unsigned CW = $clog2(FRAME_LEN + 1);
  localparam logic [BW-1:0] LAST_BIN = BW'(VALUE_BINS - 1);
  localparam logic [CW-1:0] FRAME_MAX = CW'(FRAME_LEN);

  logic [CW-1:0] bin_mem [VALUE_BINS];

  csf_state_t       state_r, state_nxt;
  logic [BW-1:0]    idx_r, idx_nxt;
  logic [BW-1:0]    val_r, val_nxt;
  logic             last_r, last_nxt;
  logic             take_r, take_nxt;
  logic [CW-1:0]    taken_r, taken_nxt;
  logic [CW-1:0]    emitted_r, emitted_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_end_r, out_end_nxt;

  logic             mem_we;
  logic [BW-1:0]    mem_wa;
  logic [CW-1:0]    mem_wd;
  logic [BW-1:0]    mem_ra;
  logic             in_range;
  logic [BW-1:0]    in_idx;
  logic [CW-1:0]    taken_after;
  logic             out_free;
  logic             is_final;

  assign in_range = 32'(in_chan.sample_value) < 32'(VALUE_BINS);
  assign in_idx   = in_range ? BW'(in_chan.sample_value) : '0;
  assign out_free = !out_valid_r || out_chan.ready;
  assign taken_after = take_r ? taken_r + CW'(1) : taken_r;
  assign is_final = (emitted_r + CW'(1)) == taken_r;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sorted_value = out_value_r;
  assign out_chan.run_end      = out_end_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= bin_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      taken_r     <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      taken_r     <= taken_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    take_r      <= take_nxt;
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    take_nxt      = take_r;
    taken_nxt     = taken_r;
    emitted_nxt   = emitted_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = '0;
    mem_ra        = idx_r;
    in_chan.ready = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        if (idx_r == LAST_BIN) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + BW'(1);
        end
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        mem_ra        = in_idx;
        if (in_chan.valid) begin
          val_nxt   = in_idx;
          last_nxt  = in_chan.frame_end;
          take_nxt  = (taken_r < FRAME_MAX) && in_range;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (take_r) begin
          mem_we = 1'b1;
          mem_wa = val_r;
          mem_wd = (rd_data_r < FRAME_MAX) ? rd_data_r + CW'(1) : rd_data_r;
        end
        taken_nxt = taken_after;
        if (last_r && taken_after != '0) begin
          idx_nxt     = '0;
          emitted_nxt = '0;
          state_nxt   = ST_SRD;
        end else begin
          if (last_r) begin
            taken_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SRD: begin
        state_nxt = ST_SGET;
      end
      ST_SGET: begin
        mem_we  = 1'b1;
        cnt_nxt = rd_data_r;
        if (rd_data_r != '0) begin
          state_nxt = ST_SEMIT;
        end else if (idx_r == LAST_BIN) begin
          taken_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + BW'(1);
          state_nxt = ST_SRD;
        end
      end
      ST_SEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = VAL_W'(idx_r);
          out_end_nxt   = is_final;
          emitted_nxt   = emitted_r + CW'(1);
          cnt_nxt       = cnt_r - CW'(1);
          if (is_final || (cnt_r == CW'(1) && idx_r == LAST_BIN)) begin
            taken_nxt = '0;
            state_nxt = ST_IDLE;
          end else if (cnt_r == CW'(1)) begin
            idx_nxt   = idx_r + BW'(1);
            state_nxt = ST_SRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `CSF_ASSERT_SAME(a_no_write_idle, state_r == ST_IDLE, !mem_we, "Histogram written while idle.")
  `CSF_ASSERT_SAME(a_taken_bound, 1'b1, taken_r <= FRAME_MAX, "Item count exceeds frame length.")
  `CSF_ASSERT_SAME(a_emit_bound, state_r == ST_SEMIT, emitted_r < taken_r,
                   "More results than counted items.")
  `CSF_ASSERT_NEXT(a_accept_acc, in_chan.valid && in_chan.ready, state_r == ST_ACC,
                   "Accepted request did not enter accumulate.")

endmodule

// File: test/counting_sort_frame_unit_checker.sv
// Channel monitor that predicts each frame's sorted run and compares the unit's results.
module counting_sort_frame_unit_checker import csf_pkg::*; #(
  parameter int unsigned VALUE_BINS = 128,
  parameter int unsigned FRAME_LEN  = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [VAL_W-1:0] in_sample_value,
  input  logic             in_frame_end,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [VAL_W-1:0] out_sorted_value,
  input  logic             out_run_end,
  output int unsigned      mismatch_count,
  output int unsigned      results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             run_end;
  } sorted_item_t;

  sorted_item_t sorted_run_q[$];
  int unsigned  bin_tally[VALUE_BINS];
  int unsigned  frame_fill;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic clear_histogram();
    for (int unsigned b = 0; b < VALUE_BINS; b++) begin
      bin_tally[b] = 0;
    end
    frame_fill = 0;
  endtask

  task automatic tally_sample(input logic [VAL_W-1:0] v, input logic last);
    sorted_item_t item;
    int unsigned  emitted;
    emitted = 0;
    // Once the frame is full, further values are dropped, but an end mark still closes it.
    if (frame_fill < FRAME_LEN && v < VALUE_BINS) begin
      if (bin_tally[v] < FRAME_LEN) begin
        bin_tally[v]++;
      end
      frame_fill++;
    end
    if (last) begin
      for (int unsigned b = 0; b < VALUE_BINS; b++) begin
        for (int unsigned c = 0; c < bin_tally[b] && emitted < FRAME_LEN; c++) begin
          item.sorted_value = VAL_W'(b);
          item.run_end = 1'b0;
          sorted_run_q.push_back(item);
          emitted++;
        end
      end
      if (emitted > 0) begin
        item = sorted_run_q.pop_back();
        item.run_end = 1'b1;
        sorted_run_q.push_back(item);
      end
      clear_histogram();
    end
  endtask

  always @(posedge clk) begin : monitor
    sorted_item_t want;
    if (!rst_n) begin
      sorted_run_q.delete();
      clear_histogram();
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_run_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", out_sorted_value));
        end else begin
          want = sorted_run_q.pop_front();
          if (out_sorted_value !== want.sorted_value) begin
            report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                      out_sorted_value, want.sorted_value));
          end
          if (out_run_end !== want.run_end) begin
            report_mismatch($sformatf("run_end %0b, expected %0b on value %0d",
                                      out_run_end, want.run_end, want.sorted_value));
          end
        end
      end
      if (in_valid && in_ready) begin
        tally_sample(in_sample_value, in_frame_end);
      end
    end
    results_due = sorted_run_q.size();
  end

endmodule

// File: test/counting_sort_frame_unit_tb.sv
// Stimulus, flow control and verdict for the counting sort frame unit.
module counting_sort_frame_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csf_pkg::*;

  localparam int unsigned VALUE_BINS   = 128;
  localparam int unsigned FRAME_LEN    = 64;
  localparam int unsigned ITEM_TARGET  = 450;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 320;
  localparam int unsigned IDLE_LIMIT   = 3000;

  bit          clk;
  logic        rst_n = 1'b0;
  int unsigned mismatch_count;
  int unsigned results_due;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          source_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          hold_request = 1'b0;

  csf_in_if  in_chan ();
  csf_out_if out_chan ();

  counting_sort_frame_unit #(
    .VALUE_BINS(VALUE_BINS),
    .FRAME_LEN (FRAME_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  counting_sort_frame_unit_checker #(
    .VALUE_BINS(VALUE_BINS),
    .FRAME_LEN (FRAME_LEN)
  ) sort_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_sample_value (in_chan.sample_value),
    .in_frame_end    (in_chan.frame_end),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_sorted_value(out_chan.sorted_value),
    .out_run_end     (out_chan.run_end),
    .mismatch_count  (mismatch_count),
    .results_due     (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_chan.ready <= !(sink_gaps && $urandom_range(0, 99) < 12);
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles.", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [VAL_W-1:0] v, input logic last);
    while (source_gaps && $urandom_range(0, 99) < 12) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample_value <= v;
    in_chan.frame_end    <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned len, input int unsigned lo,
                            input int unsigned hi);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(VAL_W'($urandom_range(hi, lo)), i == len - 1);
    end
  endtask

  task automatic wait_for_sorted_runs();
    in_chan.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned base;
    int unsigned hi;
    in_chan.valid        <= 1'b0;
    in_chan.sample_value <= '0;
    in_chan.frame_end    <= 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_sample(7'd0, 1'b1);
    send_sample(7'd127, 1'b1);
    send_sample(7'd127, 1'b0);
    send_sample(7'd0, 1'b0);
    send_sample(7'd64, 1'b0);
    send_sample(7'd0, 1'b0);
    send_sample(7'd127, 1'b0);
    send_sample(7'd1, 1'b1);
    send_sample(7'd85, 1'b0);
    send_sample(7'd42, 1'b0);
    send_sample(7'd85, 1'b0);
    send_sample(7'd42, 1'b1);
    send_frame(3, 5, 5);
    wait_for_sorted_runs();

    // The receiver stalls while whole frames keep arriving, so the unit backs up.
    hold_request = 1'b1;
    repeat (3) send_frame(8, 0, 127);
    wait_for_sorted_runs();

    while (items_sent < ITEM_TARGET) begin
      source_gaps = !(items_sent >= 180 && items_sent < 280);
      sink_gaps   = source_gaps;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_frame($urandom_range(80, FRAME_LEN + 1), 0, 127);
      end else if (pick == 1) begin
        base = $urandom_range(0, 127);
        send_frame($urandom_range(70, FRAME_LEN), base, base);
      end else if (pick < 9) begin
        base = $urandom_range(0, 127);
        hi = base + $urandom_range(0, 3);
        if (hi > 127) begin
          hi = 127;
        end
        send_frame($urandom_range(16, 1), base, hi);
      end else begin
        send_frame($urandom_range(20, 1), 0, 127);
      end
      if ($urandom_range(0, 7) == 0) begin
        wait_for_sorted_runs();
      end
    end

    wait_for_sorted_runs();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
